@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on i_clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define VP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define VP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hw/rtl/vpdc_pkg.sv @@
// ----------------------------------------------------------------------------
// vpdc_pkg
// Types and constants of the voice preamp / DC blocker / limiter.
// ----------------------------------------------------------------------------
package vpdc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int PADDR_W     = 3;

    localparam logic REG_STEREO = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    localparam logic [14:0] LIMIT_RESET = 15'd28000;

    // floor(p / 13) = (p * ceil(2^24 / 13)) >> 24, exact for p < 2^20
    localparam int          GAIN_SHIFT = 24;
    localparam logic [20:0] GAIN_RECIP = 21'd1290556;

    // floor(c / 25) = (c * ceil(2^28 / 25)) >> 28, exact for c < 2^23
    localparam int          DECAY_SHIFT = 28;
    localparam logic [23:0] DECAY_RECIP = 24'd10737419;
    localparam logic [7:0]  DECAY_BIAS  = 8'd199;

    typedef struct packed {
        logic signed [15:0] sample_in;
        logic               start_of_stream;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               channel_index;
        logic               was_limited;
    } t_out_word;

    typedef struct packed {
        logic signed [17:0] delta;
        logic               chan;
        logic               sos;
    } t_cmd;

endpackage

@@ hw/rtl/vpdc_front.sv @@
// ----------------------------------------------------------------------------
// vpdc_front
// Accepts words, assigns the channel, applies the 200/130 gain and forms
// the input difference x - x_prev per channel.
// ----------------------------------------------------------------------------
module vpdc_front
    import vpdc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_stereo,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_data,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    logic               r_par;
    logic               r_f1_v;
    logic               r_f1_neg;
    logic               r_f1_ch;
    logic               r_f1_sos;
    logic [19:0]        r_f1_mag20;
    logic               r_f2_v;
    logic               r_f2_ch;
    logic               r_f2_sos;
    logic signed [16:0] r_f2_x;
    logic signed [16:0] r_xp [2];

    logic               f1_ready;
    logic               f2_ready;
    logic               accept;
    logic               push;
    logic               par_cur;
    logic               ch_in;
    logic [15:0]        raw_u;
    logic [15:0]        mag16;
    logic [19:0]        mag20;
    logic [40:0]        gain_prod;
    logic [16:0]        gain_q;
    logic signed [16:0] q_s;
    logic signed [16:0] x_new;
    logic signed [16:0] xp;

    assign f2_ready = !r_f2_v || i_cmd_ready;
    assign f1_ready = !r_f1_v || f2_ready;
    assign o_ready  = f1_ready;
    assign accept   = i_valid && f1_ready;
    assign push     = r_f2_v && i_cmd_ready;

    assign par_cur = i_data.start_of_stream ? 1'b0 : r_par;
    assign ch_in   = i_stereo & par_cur;
    assign raw_u   = i_data.sample_in;
    assign mag16   = raw_u[15] ? (~raw_u + 16'd1) : raw_u;
    assign mag20   = {mag16, 4'b0000} + {2'b00, mag16, 2'b00};

    assign gain_prod = 41'(r_f1_mag20) * 41'(GAIN_RECIP);
    assign gain_q    = gain_prod[GAIN_SHIFT +: 17];
    assign q_s       = $signed(gain_q);
    assign x_new     = r_f1_neg ? -q_s : q_s;

    assign xp = r_f2_sos ? 17'sd0 : r_xp[r_f2_ch];

    assign o_cmd_valid = r_f2_v;
    assign o_cmd.delta = {r_f2_x[16], r_f2_x} - {xp[16], xp};
    assign o_cmd.chan  = r_f2_ch;
    assign o_cmd.sos   = r_f2_sos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par   <= 1'b0;
            r_f1_v  <= 1'b0;
            r_f2_v  <= 1'b0;
            r_xp[0] <= '0;
            r_xp[1] <= '0;
        end else begin
            if (accept) begin
                r_par <= ~par_cur;
            end
            if (f1_ready) begin
                r_f1_v <= i_valid;
            end
            if (f2_ready) begin
                r_f2_v <= r_f1_v;
            end
            if (push) begin
                if (r_f2_sos) begin
                    r_xp[~r_f2_ch] <= '0;
                end
                r_xp[r_f2_ch] <= r_f2_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_neg   <= raw_u[15];
            r_f1_ch    <= ch_in;
            r_f1_sos   <= i_data.start_of_stream;
            r_f1_mag20 <= mag20;
        end
        if (f2_ready && r_f1_v) begin
            r_f2_x   <= x_new;
            r_f2_ch  <= r_f1_ch;
            r_f2_sos <= r_f1_sos;
        end
    end

endmodule

@@ hw/rtl/vpdc_fifo.sv @@
// ----------------------------------------------------------------------------
// vpdc_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module vpdc_fifo
    import vpdc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

@@ hw/rtl/vpdc_back.sv @@
// ----------------------------------------------------------------------------
// vpdc_back
// Per-channel feedback y = delta + y_prev*995/1000, clamp, output register.
// ----------------------------------------------------------------------------
module vpdc_back
    import vpdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [14:0] i_limit,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_word   o_data
);

    logic signed [26:0] r_yp [2];
    logic               r_o_v;
    t_out_word          r_o_data;

    logic               take;
    logic signed [26:0] yp;
    logic               yp_neg;
    logic [26:0]        yp_u;
    logic [26:0]        mag;
    logic [27:0]        biased;
    logic [24:0]        c25;
    logic [48:0]        dprod;
    logic [20:0]        dq;
    logic [26:0]        dmag;
    logic signed [26:0] dec;
    logic signed [26:0] y;
    logic signed [26:0] lim;
    logic signed [26:0] lim_n;
    logic signed [26:0] clamped;
    logic               limited;

    assign o_cmd_ready = !r_o_v || i_ready;
    assign take        = i_cmd_valid && o_cmd_ready;

    // trunc(y*995/1000) = sign(y) * (|y| - ceil(|y|/200))
    assign yp     = i_cmd.sos ? 27'sd0 : r_yp[i_cmd.chan];
    assign yp_neg = yp[26];
    assign yp_u   = yp;
    assign mag    = yp_neg ? (~yp_u + 27'd1) : yp_u;
    assign biased = {1'b0, mag} + 28'(DECAY_BIAS);
    assign c25    = biased[27:3];
    assign dprod  = 49'(c25) * 49'(DECAY_RECIP);
    assign dq     = dprod[DECAY_SHIFT +: 21];
    assign dmag   = mag - 27'(dq);
    assign dec    = yp_neg ? -$signed(dmag) : $signed(dmag);
    assign y      = {{9{i_cmd.delta[17]}}, i_cmd.delta} + dec;

    assign lim   = $signed({12'd0, i_limit});
    assign lim_n = -lim;

    always_comb begin
        clamped = y;
        limited = 1'b0;
        priority if (y > lim) begin
            clamped = lim;
            limited = 1'b1;
        end else if (y < lim_n) begin
            clamped = lim_n;
            limited = 1'b1;
        end
    end

    assign o_valid = r_o_v;
    assign o_data  = r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v   <= 1'b0;
            r_yp[0] <= '0;
            r_yp[1] <= '0;
        end else begin
            if (o_cmd_ready) begin
                r_o_v <= i_cmd_valid;
            end
            if (take) begin
                if (i_cmd.sos) begin
                    r_yp[~i_cmd.chan] <= '0;
                end
                r_yp[i_cmd.chan] <= y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_data.sample_out    <= clamped[15:0];
            r_o_data.channel_index <= i_cmd.chan;
            r_o_data.was_limited   <= limited;
        end
    end

endmodule

@@ hw/rtl/voice_preamp_dc_block_limiter_top.sv @@
// ----------------------------------------------------------------------------
// voice_preamp_dc_block_limiter_top
// Preamp gain 200/130, one-pole DC blocker and symmetric limiter for PCM.
// ----------------------------------------------------------------------------
// Takes one word per clock and delivers one word per clock when the sink
// keeps up. Accepted words pass front registers f1 and f2, the queue and the
// back output register. The per-channel filter feedback (reciprocal
// multiply by 1/200 plus add) closes combinationally in the back stage, so
// the same channel can be fed every cycle. A short queue between front and
// back absorbs output stalls. Registers: 0x0 stereo_mode, 0x4 limit_level.
// ----------------------------------------------------------------------------
module voice_preamp_dc_block_limiter_top
    import vpdc_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_in_word           i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output t_out_word          o_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic        r_stereo;
    logic [14:0] r_limit;

    logic        cfg_wr;
    logic        fq_valid;
    logic        fq_ready;
    t_cmd        fq_cmd;
    logic        qb_valid;
    logic        qb_ready;
    t_cmd        qb_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo <= 1'b0;
            r_limit  <= LIMIT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_STEREO: r_stereo <= pwdata[0];
                REG_LIMIT:  r_limit  <= pwdata[14:0];
                default:    r_stereo <= r_stereo;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_STEREO: prdata = {31'd0, r_stereo};
            REG_LIMIT:  prdata = {17'd0, r_limit};
            default:    prdata = '0;
        endcase
    end

    vpdc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stereo    (r_stereo),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_cmd_valid (fq_valid),
        .i_cmd_ready (fq_ready),
        .o_cmd       (fq_cmd)
    );

    vpdc_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_cmd   (fq_cmd),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_cmd   (qb_cmd)
    );

    vpdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_limit),
        .i_cmd_valid (qb_valid),
        .o_cmd_ready (qb_ready),
        .i_cmd       (qb_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

@@ hw/rtl/vpdc_checker.sv @@
// ----------------------------------------------------------------------------
// vpdc_checker
// Port-level checks of the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vpdc_checker
    import vpdc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input t_out_word          o_data,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready
);

    logic [7:0]  r_cnt;
    logic [31:0] r_wd;
    logic        in_acc;
    logic        out_acc;
    logic        cfg_wr;
    logic        sel_st;
    logic        sel_lim;
    logic        wr_st;
    logic        wr_lim;
    logic        st_ok;
    logic        lim_ok;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign sel_st  = (paddr[2] == REG_STEREO);
    assign sel_lim = (paddr[2] == REG_LIMIT);
    assign wr_st   = cfg_wr && sel_st;
    assign wr_lim  = cfg_wr && sel_lim;
    assign st_ok   = !sel_st || (prdata[0] == r_wd[0]);
    assign lim_ok  = !sel_lim || (prdata[14:0] == r_wd[14:0]);

    // words in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {7'd0, in_acc} - {7'd0, out_acc};
        end
    end

    // last cycle's write data
    always_ff @(posedge i_clk) begin
        r_wd <= pwdata;
    end

    `VP_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !o_valid, "output valid after reset")
    `VP_ASSERT(a_out_hold, (o_valid && !i_ready) |=> (o_valid && $stable(o_data)), "stall lost")
    `VP_ASSERT(a_no_extra, out_acc |-> (r_cnt != 8'd0), "output word without input word")
    `VP_ASSERT(a_stereo_rb, wr_st |=> st_ok, "stereo readback")
    `VP_ASSERT(a_limit_rb, wr_lim |=> lim_ok, "limit readback")

endmodule

bind voice_preamp_dc_block_limiter_top vpdc_checker u_vpdc_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the voice preamp / DC blocker / limiter.
// ----------------------------------------------------------------------------
// A queue-fed driver offers PCM words and a monitor checks every output word
// against a local model of gain, one-pole high-pass and clamp, kept per
// channel. Directed words hit the sample extremes, zero limit and a mode
// change mid-stream, then random phases sweep stereo mode and limit level.
// Both sides idle in short bursts. One phase holds the sink off long enough
// to back up the block, another drains fully before continuing.
// ----------------------------------------------------------------------------
module tb;
    import vpdc_pkg::*;

    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  HOLD_CYCLES  = 64;
    localparam int  DRAIN_CYCLES = 12;
    localparam int  NUM_PHASES   = 8;
    localparam int  PHASE_WORDS  = 78;

    localparam longint GAIN_NUM  = 200;
    localparam longint GAIN_DEN  = 130;
    localparam longint DECAY_NUM = 995;
    localparam longint DECAY_DEN = 1000;

    localparam logic [PADDR_W-1:0] ADDR_STEREO = {REG_STEREO, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_LIMIT  = {REG_LIMIT, 2'b00};

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    t_in_word           i_data  = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    t_out_word          o_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    voice_preamp_dc_block_limiter_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model state and configuration
    logic        cfg_stereo = 1'b0;
    logic [14:0] cfg_limit  = LIMIT_RESET;
    longint      held_in[2];
    longint      held_out[2];
    logic        parity = 1'b0;

    t_in_word  pcm_pending[$];
    t_out_word pcm_expected[$];

    int  errors      = 0;
    int  words_in    = 0;
    int  words_out   = 0;
    int  clamped_cnt = 0;
    int  cycles      = 0;
    bit  steady      = 1'b0;
    int  hold_req    = 0;
    int  hold_ack    = 0;
    int  hold_cnt    = 0;
    int  src_gap     = 0;
    int  snk_gap     = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_out_word dcblock_predict(t_in_word w);
        longint   scaled;
        longint   filt;
        longint   clamped;
        longint   lim;
        logic     ch;
        t_out_word r;
        if (w.start_of_stream) begin
            held_in[0]  = 0;
            held_in[1]  = 0;
            held_out[0] = 0;
            held_out[1] = 0;
            parity      = 1'b0;
        end
        ch = cfg_stereo ? parity : 1'b0;
        parity = ~parity;
        lim = longint'(cfg_limit);
        scaled = (longint'($signed(w.sample_in)) * GAIN_NUM) / GAIN_DEN;
        filt = scaled - held_in[ch] + (held_out[ch] * DECAY_NUM) / DECAY_DEN;
        held_in[ch]  = scaled;
        held_out[ch] = filt;
        clamped = filt;
        if (clamped > lim) clamped = lim;
        else if (clamped < -lim) clamped = -lim;
        r.sample_out    = 16'(clamped);
        r.channel_index = ch;
        r.was_limited   = (clamped != filt);
        return r;
    endfunction

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (i_valid && o_ready) begin
                pcm_expected.push_back(dcblock_predict(i_data));
                words_in++;
            end
            if (!i_valid || o_ready) begin
                if (src_gap > 0) begin
                    i_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (pcm_pending.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (!steady && $urandom_range(0, 5) == 0) begin
                    i_valid <= 1'b0;
                    src_gap <= $urandom_range(0, 3);
                end else begin
                    i_data  <= pcm_pending.pop_front();
                    i_valid <= 1'b1;
                end
            end
        end
    end

    // sink side and checking
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            snk_gap <= 0;
        end else begin
            if (o_valid && i_ready) begin
                words_out++;
                if (o_data.was_limited) clamped_cnt++;
                if (pcm_expected.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, got sample %0d ch %0d lim %0d",
                             $time, o_data.sample_out, o_data.channel_index,
                             o_data.was_limited);
                end else begin
                    want = pcm_expected.pop_front();
                    if (o_data.sample_out !== want.sample_out ||
                        o_data.channel_index !== want.channel_index ||
                        o_data.was_limited !== want.was_limited) begin
                        errors++;
                        $display("%0t: mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 $time, want.sample_out, want.channel_index,
                                 want.was_limited, o_data.sample_out,
                                 o_data.channel_index, o_data.was_limited);
                    end
                end
            end
            if (hold_req != hold_ack) begin
                hold_ack <= hold_req;
                hold_cnt <= HOLD_CYCLES;
                i_ready  <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_ready  <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                i_ready <= 1'b0;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
                snk_gap <= $urandom_range(0, 3);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time, pcm_expected.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_STEREO) cfg_stereo = val[0];
        else if (addr == ADDR_LIMIT) cfg_limit = val[14:0];
    endtask

    // sampled at the falling edge so the driver's updates have settled
    task automatic wait_drained();
        while (pcm_pending.size() != 0 || i_valid || pcm_expected.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_word(input logic sos, input logic signed [15:0] s);
        t_in_word w;
        w.sample_in       = s;
        w.start_of_stream = sos;
        pcm_pending.push_back(w);
    endtask

    function automatic logic signed [15:0] pick_sample(logic signed [15:0] dc_level);
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($signed($urandom_range(0, 127)) - 64);
            3, 4:    return dc_level;
            default: return r[15:0];
        endcase
    endfunction

    initial begin
        logic signed [15:0] dc_level;
        logic [14:0]        lim_val;
        held_in[0]  = 0;
        held_in[1]  = 0;
        held_out[0] = 0;
        held_out[1] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // mono at reset limit: extremes and a restart mid-stream
        push_word(1'b1, 16'sh7FFF);
        push_word(1'b0, 16'sh7FFF);
        push_word(1'b0, 16'sh7FFF);
        push_word(1'b0, 16'sh8000);
        push_word(1'b0, 16'sh8000);
        push_word(1'b0, 16'sh8000);
        push_word(1'b0, 16'sd0);
        push_word(1'b0, -16'sd1);
        push_word(1'b0, 16'sd1);
        push_word(1'b1, 16'sh8000);
        push_word(1'b0, 16'sd0);
        wait_drained();

        // zero limit
        reg_write(ADDR_LIMIT, 32'd0);
        push_word(1'b1, 16'sd1000);
        push_word(1'b0, 16'sd0);
        push_word(1'b0, 16'sd0);
        push_word(1'b0, -16'sd1000);
        wait_drained();

        // stereo switched on with state kept, then a fresh stream
        reg_write(ADDR_STEREO, 32'd1);
        reg_write(ADDR_LIMIT, 32'd32767);
        push_word(1'b0, 16'sh7FFF);
        push_word(1'b0, 16'sh8000);
        push_word(1'b1, 16'sh7FFF);
        push_word(1'b0, 16'sh8000);
        push_word(1'b0, 16'sh7FFF);
        push_word(1'b0, 16'sh8000);
        push_word(1'b0, 16'sd0);
        push_word(1'b0, 16'sd0);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       lim_val = LIMIT_RESET;
                1:       lim_val = 15'd32767;
                2:       lim_val = 15'd1;
                4:       lim_val = 15'd0;
                6:       lim_val = 15'd16384;
                default: lim_val = 15'($urandom_range(0, 32767));
            endcase
            reg_write(ADDR_STEREO, 32'(ph[0] ^ (ph > 3)));
            reg_write(ADDR_LIMIT, 32'(lim_val));
            if (ph == NUM_PHASES - 1) steady = 1'b1;
            dc_level = $urandom();
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (ph == 4 && k == PHASE_WORDS / 2) wait_drained();
                push_word((k == 0 && ph[0] == 1'b0) || $urandom_range(0, 49) == 0,
                          pick_sample(dc_level));
            end
            if (ph == 2) hold_req++;
            wait_drained();
        end

        while (pcm_pending.size() != 0 || i_valid) @(posedge i_clk);
        for (int n = 0; n < 500 && pcm_expected.size() != 0; n++) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pcm_expected.size() != 0) begin
            errors++;
            $display("%0t: %0d expected words never arrived", $time, pcm_expected.size());
        end

        $display("%0d words in, %0d out, %0d clamped", words_in, words_out, clamped_cnt);
        $display("mono and stereo, limits 0 to 32767, long sink stall and full drain");
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/vpdc_pkg.sv
hw/rtl/vpdc_front.sv
hw/rtl/vpdc_fifo.sv
hw/rtl/vpdc_back.sv
hw/rtl/voice_preamp_dc_block_limiter_top.sv
hw/rtl/vpdc_checker.sv
tb/tb.sv
